FILE: design/prg_bank_page_mapper_unit_assert.svh
// Assertion macros shared by the page mapper RTL.
`ifndef PRG_BANK_PAGE_MAPPER_UNIT_ASSERT_SVH
`define PRG_BANK_PAGE_MAPPER_UNIT_ASSERT_SVH

// Condition and consequence in the same cycle.
`define PBPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define PBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/prg_bpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prg_bpm_pkg;

    // Address space geometry
    localparam int PAGE_COUNT          = 32;
    localparam int PAGE_IDX_W          = $clog2(PAGE_COUNT);
    localparam int PAGE_OFS_W          = 11;
    localparam int ADDR_W              = 16;
    localparam int MAX_CHIP_PAGES_LOG2 = 9;

    // Field widths
    localparam int OP_W     = 2;
    localparam int WIN_W    = 3;
    localparam int BANK_W   = 9;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PHYS_W   = 20;
    localparam int KIND_W   = 2;
    localparam int LOG2_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // Largest window code (32KB = 16 pages)
    localparam logic [WIN_W-1:0] WIN_CODE_MAX = 3'd4;
    localparam int WIN_SHIFT_MAX = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SELECT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

    // Page kinds
    localparam logic [KIND_W-1:0] KIND_MAPPED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ZERO   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MAPPED      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_PAGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OPEN_BUS    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SELECT_DONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHIP0_PAGES_LOG2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHIP0_IS_RAM     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHIP0_PRESENT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHIP1_PAGES_LOG2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHIP1_IS_RAM     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHIP1_PRESENT    = 3'd5;

    // Input item
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic              chip_sel;
        logic [WIN_W-1:0]  window;
        logic [BANK_W-1:0] bank;
        logic [DATA_W-1:0] write_data;
    } cmd_t;

    // Result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                chip_out;
        logic [PHYS_W-1:0]   phys_addr;
        logic                write_enable;
        logic [DATA_W-1:0]   write_data_out;
    } result_t;

    // Bank-select request to the page table, chip config already selected
    typedef struct packed {
        logic [PAGE_IDX_W-1:0] first;
        logic [WIN_W-1:0]      window;
        logic [BANK_W-1:0]     bank;
        logic                  chip;
        logic [LOG2_W-1:0]     pages_log2;
        logic                  is_ram;
        logic                  present;
    } map_req_t;

    // Page table lookup, page number travels separately
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              ram;
        logic              chip;
    } lookup_t;

endpackage

`default_nettype wire

FILE: design/prg_bpm_page_table.sv
`timescale 1ns / 1ps
`default_nettype none
`include "prg_bank_page_mapper_unit_assert.svh"

module prg_bpm_page_table
    import prg_bpm_pkg::*;
#(
    parameter int MAX_CHIP_PAGES_LOG2 = prg_bpm_pkg::MAX_CHIP_PAGES_LOG2
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           map_en,
    input  wire map_req_t                       map_req,
    input  wire logic [PAGE_IDX_W-1:0]          look_idx,
    output lookup_t                             look,
    output logic [MAX_CHIP_PAGES_LOG2-1:0]      look_page
);

    localparam int PG_W  = MAX_CHIP_PAGES_LOG2;
    localparam int SUM_W = (PG_W > BANK_W + WIN_SHIFT_MAX) ? PG_W : BANK_W + WIN_SHIFT_MAX;

    logic [KIND_W-1:0] kind_reg [PAGE_COUNT];
    logic              ram_reg  [PAGE_COUNT];
    logic              chip_reg [PAGE_COUNT];
    logic [PG_W-1:0]   page_reg [PAGE_COUNT];

    logic [LOG2_W-1:0] lg_sat;
    logic [SUM_W-1:0]  chip_mask;
    logic [SUM_W-1:0]  bank_base;
    logic              hit    [PAGE_COUNT];
    logic [PG_W-1:0]   pg_new [PAGE_COUNT];
    logic [KIND_W-1:0] kind_new;

    // Chip size mask, saturated to the page field
    always_comb
    begin
        if (map_req.pages_log2 > LOG2_W'(PG_W))
            lg_sat = LOG2_W'(PG_W);
        else
            lg_sat = map_req.pages_log2;
        for (int j = 0; j < SUM_W; j++)
            chip_mask[j] = (j < int'(lg_sat));
    end

    // Window start in pages; the offset inside the window only fills low zero bits
    assign bank_base = SUM_W'(map_req.bank) << map_req.window;
    assign kind_new  = map_req.present ? KIND_MAPPED : KIND_OPEN;

    // Per-slot window membership and page number
    always_comb
    begin
        logic [PAGE_IDX_W-1:0] ofs;
        for (int s = 0; s < PAGE_COUNT; s++)
        begin
            ofs       = PAGE_IDX_W'(s) - map_req.first;
            hit[s]    = (PAGE_IDX_W'(s) >= map_req.first) && ((ofs >> map_req.window) == '0);
            pg_new[s] = PG_W'((bank_base | SUM_W'(ofs)) & chip_mask);
        end
    end

    // Table storage: kind is control, the rest is payload
    for (genvar s = 0; s < PAGE_COUNT; s++)
    begin : g_slot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                kind_reg[s] <= KIND_ZERO;
            else if (map_en && hit[s])
                kind_reg[s] <= kind_new;
        end

        always_ff @(posedge clk)
        begin
            if (map_en && hit[s])
            begin
                ram_reg[s]  <= map_req.is_ram;
                chip_reg[s] <= map_req.chip;
                page_reg[s] <= pg_new[s];
            end
        end
    end

    // Lookup port
    assign look.kind = kind_reg[look_idx];
    assign look.ram  = ram_reg[look_idx];
    assign look.chip = chip_reg[look_idx];
    assign look_page = page_reg[look_idx];

    // The window's first page is always rewritten
    `PBPM_ASSERT_NEXT(a_first_slot_written, clk, rst_n, map_en,
        kind_reg[$past(map_req.first)] == ($past(map_req.present) ? KIND_MAPPED : KIND_OPEN),
        "bank select did not update the first page of its window")

endmodule

`default_nettype wire

FILE: design/prg_bank_page_mapper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "prg_bank_page_mapper_unit_assert.svh"

// Program memory page mapper. Takes one item per clock: busy never rises,
// so start may be held high every cycle. Each item gives one result on
// result, marked by done for one cycle. An item passes through the input
// register, which takes it, and then the result register, which is loaded
// after the page table lookup/update; done rises as the result register
// is loaded. Results come out in item order and cannot be stalled; the
// receiver must take done whenever it is high. A bank select updates all
// pages of its window at once, so a read right behind it already sees the
// new mapping. Configuration writes are always ready and should be made
// with no item in flight.
module prg_bank_page_mapper_unit
    import prg_bpm_pkg::*;
#(
    parameter int MAX_CHIP_PAGES_LOG2 = prg_bpm_pkg::MAX_CHIP_PAGES_LOG2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire cmd_t                  cmd,
    output logic                       done,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic              in_valid_reg;
    cmd_t              in_item_reg;
    logic              done_reg;
    result_t           result_reg;
    result_t           result_next;

    logic [LOG2_W-1:0] chip0_pages_log2_reg;
    logic              chip0_is_ram_reg;
    logic              chip0_present_reg;
    logic [LOG2_W-1:0] chip1_pages_log2_reg;
    logic              chip1_is_ram_reg;
    logic              chip1_present_reg;

    logic                           accept;
    logic                           map_en;
    map_req_t                       map_req;
    lookup_t                        look;
    logic [MAX_CHIP_PAGES_LOG2-1:0] look_page;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip0_pages_log2_reg <= '0;
            chip0_is_ram_reg     <= 1'b0;
            chip0_present_reg    <= 1'b0;
            chip1_pages_log2_reg <= '0;
            chip1_is_ram_reg     <= 1'b0;
            chip1_present_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHIP0_PAGES_LOG2: chip0_pages_log2_reg <= cfg_data;
                REG_CHIP0_IS_RAM:     chip0_is_ram_reg     <= cfg_data[0];
                REG_CHIP0_PRESENT:    chip0_present_reg    <= cfg_data[0];
                REG_CHIP1_PAGES_LOG2: chip1_pages_log2_reg <= cfg_data;
                REG_CHIP1_IS_RAM:     chip1_is_ram_reg     <= cfg_data[0];
                REG_CHIP1_PRESENT:    chip1_present_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= cmd;
    end

    // Bank-select request with the chosen chip's config
    always_comb
    begin
        map_req.first  = in_item_reg.addr[ADDR_W-1 -: PAGE_IDX_W];
        map_req.window = (in_item_reg.window > WIN_CODE_MAX) ? WIN_CODE_MAX
                                                             : in_item_reg.window;
        map_req.bank   = in_item_reg.bank;
        map_req.chip   = in_item_reg.chip_sel;
        if (in_item_reg.chip_sel)
        begin
            map_req.pages_log2 = chip1_pages_log2_reg;
            map_req.is_ram     = chip1_is_ram_reg;
            map_req.present    = chip1_present_reg;
        end
        else
        begin
            map_req.pages_log2 = chip0_pages_log2_reg;
            map_req.is_ram     = chip0_is_ram_reg;
            map_req.present    = chip0_present_reg;
        end
    end

    assign map_en = in_valid_reg && (in_item_reg.op == OP_SELECT);

    prg_bpm_page_table #(
        .MAX_CHIP_PAGES_LOG2 (MAX_CHIP_PAGES_LOG2)
    ) u_page_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .map_en    (map_en),
        .map_req   (map_req),
        .look_idx  (in_item_reg.addr[ADDR_W-1 -: PAGE_IDX_W]),
        .look      (look),
        .look_page (look_page)
    );

    // Result decode
    always_comb
    begin
        result_next = '0;
        result_next.status = ST_OPEN_BUS;
        unique case (in_item_reg.op)
            OP_SELECT:
                result_next.status = ST_SELECT_DONE;
            OP_READ, OP_WRITE:
            begin
                if (in_item_reg.op == OP_WRITE)
                    result_next.write_data_out = in_item_reg.write_data;
                if (look.kind == KIND_MAPPED)
                begin
                    result_next.status       = ST_MAPPED;
                    result_next.chip_out     = look.chip;
                    result_next.phys_addr    =
                        PHYS_W'({look_page, in_item_reg.addr[PAGE_OFS_W-1:0]});
                    result_next.write_enable = (in_item_reg.op == OP_WRITE) && look.ram;
                end
                else if (look.kind == KIND_ZERO)
                    result_next.status = ST_ZERO_PAGE;
                else
                    result_next.status = ST_OPEN_BUS;
            end
            default:
                result_next.status = ST_OPEN_BUS;
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `PBPM_ASSERT_NEXT(a_accept_to_stage, clk, rst_n, accept, in_valid_reg,
        "accepted item did not reach the input register")
    `PBPM_ASSERT_NEXT(a_stage_to_done, clk, rst_n, in_valid_reg, done,
        "staged item produced no result")
    `PBPM_ASSERT_NEXT(a_no_spurious_done, clk, rst_n, !in_valid_reg, !done,
        "result strobe without a staged item")
    `PBPM_ASSERT_NOW(a_unmapped_clean, clk, rst_n, done && (result.status != ST_MAPPED),
        (result.chip_out == 1'b0) && (result.phys_addr == '0) && !result.write_enable,
        "unmapped result carries chip, address or write enable")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import prg_bpm_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Window size codes
    localparam logic [WIN_W-1:0] WIN_2K   = 3'd0;
    localparam logic [WIN_W-1:0] WIN_4K   = 3'd1;
    localparam logic [WIN_W-1:0] WIN_8K   = 3'd2;
    localparam logic [WIN_W-1:0] WIN_16K  = 3'd3;
    localparam logic [WIN_W-1:0] WIN_32K  = 3'd4;
    localparam logic [WIN_W-1:0] WIN_OVER = 3'd7;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    localparam int STALL_LIMIT       = 1000;
    localparam int SETTLE_CYCLES     = 4;
    localparam int DRAIN_CYCLES      = 10;
    localparam int SEGMENTS          = 8;
    localparam int ITEMS_PER_SEGMENT = 250;
    localparam int MAX_PRINTED       = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    cmd_t                  cmd       = '0;
    logic                  done;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    prg_bank_page_mapper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Mirror of the page table and chip setup
    typedef struct packed {
        logic [KIND_W-1:0]              kind;
        logic                           ram;
        logic                           chip;
        logic [MAX_CHIP_PAGES_LOG2-1:0] page;
    } page_entry_t;

    page_entry_t       page_map [PAGE_COUNT];
    logic [LOG2_W-1:0] size_log2 [2];
    logic              chip_ram [2];
    logic              chip_fitted [2];

    result_t pending_results [$];
    int      mismatch_count = 0;
    int      idle_pct = 0;

    // Expectation typed into the directed table, used in place of the prediction
    bit      fixed_valid = 1'b0;
    result_t fixed_result = '0;

    // Directed table
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        cmd_t                  c;
        bit                    typed;
        result_t               want;
    } plan_row_t;

    plan_row_t plan [$];

    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endfunction

    function automatic void plan_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                      input logic sel, input logic [WIN_W-1:0] win,
                                      input logic [BANK_W-1:0] bank,
                                      input logic [DATA_W-1:0] data, input bit typed,
                                      input logic [STATUS_W-1:0] st);
        plan_row_t row;
        row = '{default: '0};
        row.c.op         = op;
        row.c.addr       = addr;
        row.c.chip_sel   = sel;
        row.c.window     = win;
        row.c.bank       = bank;
        row.c.write_data = data;
        row.typed        = typed;
        row.want.status  = st;
        // only a write passes its byte through
        if (op == OP_WRITE)
            row.want.write_data_out = data;
        plan.push_back(row);
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_CHIP0_PAGES_LOG2: size_log2[0]   = val;
            REG_CHIP0_IS_RAM:     chip_ram[0]    = val[0];
            REG_CHIP0_PRESENT:    chip_fitted[0] = val[0];
            REG_CHIP1_PAGES_LOG2: size_log2[1]   = val;
            REG_CHIP1_IS_RAM:     chip_ram[1]    = val[0];
            REG_CHIP1_PRESENT:    chip_fitted[1] = val[0];
            default: ;
        endcase
    endfunction

    // Applies one item to the page table mirror and returns its translation
    function automatic result_t translate_cmd(input cmd_t c);
        result_t     r;
        page_entry_t e;
        int          sel;
        int          first;
        int          win;
        int          lg;
        int          mask;
        int          pg;
        int          slot;
        r = '0;
        case (c.op)
            OP_SELECT:
            begin
                sel   = int'(c.chip_sel);
                first = int'(c.addr[ADDR_W-1 -: PAGE_IDX_W]);
                win   = (c.window > WIN_CODE_MAX) ? WIN_SHIFT_MAX : int'(c.window);
                lg    = (size_log2[sel] > MAX_CHIP_PAGES_LOG2) ? MAX_CHIP_PAGES_LOG2
                                                               : int'(size_log2[sel]);
                mask  = (1 << lg) - 1;
                for (int i = 0; i < (1 << win); i++)
                begin
                    slot = first + i;
                    // pages past the top of the address space are dropped
                    if (slot < PAGE_COUNT)
                    begin
                        e = '0;
                        if (chip_fitted[sel])
                        begin
                            pg     = ((int'(c.bank) << win) + i) & mask;
                            e.kind = KIND_MAPPED;
                            e.ram  = chip_ram[sel];
                            e.chip = c.chip_sel;
                            e.page = pg[MAX_CHIP_PAGES_LOG2-1:0];
                        end
                        else
                        begin
                            e.kind = KIND_OPEN;
                        end
                        page_map[slot] = e;
                    end
                end
                r.status = ST_SELECT_DONE;
            end
            OP_READ, OP_WRITE:
            begin
                e = page_map[c.addr[ADDR_W-1 -: PAGE_IDX_W]];
                if (e.kind == KIND_MAPPED)
                begin
                    r.status       = ST_MAPPED;
                    r.chip_out     = e.chip;
                    r.phys_addr    = {e.page, c.addr[PAGE_OFS_W-1:0]};
                    r.write_enable = (c.op == OP_WRITE) && e.ram;
                end
                else if (e.kind == KIND_ZERO)
                begin
                    r.status = ST_ZERO_PAGE;
                end
                else
                begin
                    r.status = ST_OPEN_BUS;
                end
                if (c.op == OP_WRITE)
                    r.write_data_out = c.write_data;
            end
            default: r.status = ST_OPEN_BUS;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Result check, then prediction of the item taken at this edge
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %h with nothing pending", result));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  result.status, want.status));
                    if (result.chip_out !== want.chip_out)
                        report_mismatch($sformatf("chip_out %0d, want %0d",
                                                  result.chip_out, want.chip_out));
                    if (result.phys_addr !== want.phys_addr)
                        report_mismatch($sformatf("phys_addr %h, want %h",
                                                  result.phys_addr, want.phys_addr));
                    if (result.write_enable !== want.write_enable)
                        report_mismatch($sformatf("write_enable %0d, want %0d",
                                                  result.write_enable, want.write_enable));
                    if (result.write_data_out !== want.write_data_out)
                        report_mismatch($sformatf("write_data_out %h, want %h",
                                                  result.write_data_out, want.write_data_out));
                end
            end
            if (start && !busy)
            begin
                want = translate_cmd(cmd);
                if (fixed_valid)
                    want = fixed_result;
                pending_results.push_back(want);
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n)
        begin
            quiet = 0;
        end
        else if ((start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Entered and left at a falling edge; each cycle idles with idle_pct odds
    task automatic send_cmd(input cmd_t c, input bit typed, input result_t want);
        fixed_valid  = typed;
        fixed_result = want;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        store_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        cmd_t                  c;
        int                    r;
        logic [CFG_DATA_W-1:0] vals [6];

        // state after reset: every page of the zero-page kind
        for (int s = 0; s < PAGE_COUNT; s++)
        begin
            page_map[s]      = '0;
            page_map[s].kind = KIND_ZERO;
        end
        for (int k = 0; k < 2; k++)
        begin
            size_log2[k]   = '0;
            chip_ram[k]    = 1'b0;
            chip_fitted[k] = 1'b0;
        end

        // zero page, unused op code, absent chip
        plan_item(OP_READ,   16'h0000, 1'b0, WIN_2K,  9'd0,   8'h00, TYPED, ST_ZERO_PAGE);
        plan_item(OP_WRITE,  16'hFFFF, 1'b0, WIN_2K,  9'd0,   8'hFF, TYPED, ST_ZERO_PAGE);
        plan_item(OP_UNUSED, 16'hFFFF, 1'b1, WIN_OVER, 9'h1FF, 8'hFF, TYPED, ST_OPEN_BUS);
        plan_item(OP_SELECT, 16'h8000, 1'b0, WIN_32K, 9'd0,   8'h00, TYPED, ST_SELECT_DONE);
        plan_item(OP_READ,   16'h8000, 1'b0, WIN_2K,  9'd0,   8'h00, TYPED, ST_OPEN_BUS);
        plan_item(OP_WRITE,  16'hC7FF, 1'b0, WIN_2K,  9'd0,   8'h5A, TYPED, ST_OPEN_BUS);
        // chip 0: oversized code saturates, RAM; chip 1: single page ROM
        plan_cfg(REG_CHIP0_PAGES_LOG2, 4'd15);
        plan_cfg(REG_CHIP0_IS_RAM,     4'd1);
        plan_cfg(REG_CHIP0_PRESENT,    4'd1);
        plan_cfg(REG_CHIP1_PAGES_LOG2, 4'd0);
        plan_cfg(REG_CHIP1_IS_RAM,     4'd0);
        plan_cfg(REG_CHIP1_PRESENT,    4'd1);
        plan_cfg(REG_SPARE_LO,         4'd15);
        plan_cfg(REG_SPARE_HI,         4'd0);
        // window code above 4, low address bits ignored, top bank
        plan_item(OP_SELECT, 16'h07FF, 1'b0, WIN_OVER, 9'h1FF, 8'hFF, TYPED, ST_SELECT_DONE);
        plan_item(OP_READ,   16'h0000, 1'b0, WIN_2K,  9'd0,   8'h00, PREDICTED, ST_MAPPED);
        plan_item(OP_WRITE,  16'h7FFF, 1'b0, WIN_2K,  9'd0,   8'hA5, PREDICTED, ST_MAPPED);
        plan_item(OP_SELECT, 16'hFFFF, 1'b1, WIN_2K,  9'h1FF, 8'h00, TYPED, ST_SELECT_DONE);
        plan_item(OP_WRITE,  16'hFFFF, 1'b0, WIN_2K,  9'd0,   8'h00, PREDICTED, ST_MAPPED);
        // window running past the top of the address space
        plan_item(OP_SELECT, 16'hF000, 1'b1, WIN_32K, 9'd0,   8'h00, PREDICTED, ST_MAPPED);
        plan_item(OP_READ,   16'hF7FF, 1'b0, WIN_2K,  9'd0,   8'h00, PREDICTED, ST_MAPPED);
        plan_item(OP_READ,   16'h0800, 1'b0, WIN_2K,  9'd0,   8'h00, PREDICTED, ST_MAPPED);
        // 4KB window selected by an address with nonzero low bits
        plan_item(OP_SELECT, 16'h1234, 1'b0, WIN_4K,  9'd3,   8'h00, PREDICTED, ST_MAPPED);
        plan_item(OP_READ,   16'h1000, 1'b0, WIN_2K,  9'd0,   8'h00, PREDICTED, ST_MAPPED);
        plan_item(OP_READ,   16'h1FFF, 1'b0, WIN_2K,  9'd0,   8'h00, PREDICTED, ST_MAPPED);
        plan_item(OP_SELECT, 16'h8000, 1'b0, WIN_16K, 9'd0,   8'h00, PREDICTED, ST_MAPPED);
        plan_item(OP_WRITE,  16'hBFFF, 1'b0, WIN_2K,  9'd0,   8'h01, PREDICTED, ST_MAPPED);
        // chip smaller than the window wraps inside the chip
        plan_cfg(REG_CHIP0_PAGES_LOG2, 4'd1);
        plan_cfg(REG_CHIP0_IS_RAM,     4'd0);
        plan_item(OP_SELECT, 16'h0000, 1'b0, WIN_32K, 9'd5,   8'h00, PREDICTED, ST_MAPPED);
        plan_item(OP_READ,   16'h1800, 1'b0, WIN_2K,  9'd0,   8'h00, PREDICTED, ST_MAPPED);
        plan_item(OP_WRITE,  16'h7800, 1'b0, WIN_2K,  9'd0,   8'hC3, PREDICTED, ST_MAPPED);
        // chip removed: its window goes open bus
        plan_cfg(REG_CHIP1_PRESENT,    4'd0);
        plan_item(OP_SELECT, 16'h4000, 1'b1, WIN_8K,  9'd1,   8'h00, TYPED, ST_SELECT_DONE);
        plan_item(OP_READ,   16'h4800, 1'b0, WIN_2K,  9'd0,   8'h00, TYPED, ST_OPEN_BUS);
        plan_item(OP_WRITE,  16'h5FFF, 1'b0, WIN_2K,  9'd0,   8'h80, TYPED, ST_OPEN_BUS);

        // reset
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        idle_pct = 28;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_register(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                send_cmd(plan[i].c, plan[i].typed, plan[i].want);
            end
        end

        // random part, one chip setup per segment
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 0)
            begin
                vals = '{4'd15, 4'd1, 4'd1, 4'd9, 4'd1, 4'd1};
            end
            else if (seg == 1)
            begin
                vals = '{4'd0, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0};
            end
            else
            begin
                for (int k = 0; k < 2; k++)
                begin
                    vals[3*k]     = CFG_DATA_W'($urandom_range(0, 15));
                    vals[3*k + 1] = CFG_DATA_W'($urandom_range(0, 1));
                    vals[3*k + 2] = CFG_DATA_W'($urandom_range(0, 3) != 0);
                end
            end
            wait_idle();
            for (int k = REG_CHIP0_PAGES_LOG2; k <= REG_CHIP1_PRESENT; k++)
                write_register(k[CFG_IDX_W-1:0], vals[k]);
            write_register(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                           CFG_DATA_W'($urandom_range(0, 15)));

            if (seg < 3)
                idle_pct = 28;
            else if (seg < 6)
                idle_pct = 69;
            else
                idle_pct = 0;

            for (int n = 0; n < ITEMS_PER_SEGMENT; n++)
            begin
                r = int'($urandom_range(99));
                if (r < 30)
                    c.op = OP_SELECT;
                else if (r < 62)
                    c.op = OP_READ;
                else if (r < 95)
                    c.op = OP_WRITE;
                else
                    c.op = OP_UNUSED;
                c.addr       = ADDR_W'($urandom);
                c.chip_sel   = 1'($urandom_range(0, 1));
                c.window     = ($urandom_range(9) == 0) ? WIN_W'($urandom_range(5, 7))
                                                        : WIN_W'($urandom_range(0, 4));
                c.bank       = BANK_W'($urandom);
                c.write_data = DATA_W'($urandom);
                send_cmd(c, PREDICTED, '0);
            end
        end

        // drain
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
